@@ src/isc_pkg.sv @@
package isc_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 5;
    localparam int LEN_W        = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_UPDATE = 2'd3;

    typedef struct packed {
        logic [1:0]               func;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]         length;
    } rsp_t;

endpackage

@@ src/isc_cells.sv @@
module isc_cells
    import isc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic exec,
    input  req_t req,
    output rsp_t rsp
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic signed [DATA_W-1:0] entries_reg  [CAPACITY];
    logic signed [DATA_W-1:0] entries_next [CAPACITY];
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;

    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic            is_insert;
    logic            is_erase;
    logic            is_find;
    logic            is_update;
    logic            ins_ok;
    logic            acc_ok;
    logic            done;
    logic [IW-1:0]   rd_idx;

    assign pos_ext   = CMPW'(req.position);
    assign cnt_ext   = CMPW'(count_reg);
    assign is_insert = (req.func == OP_INSERT);
    assign is_erase  = (req.func == OP_ERASE);
    assign is_find   = (req.func == OP_FIND);
    assign is_update = (req.func == OP_UPDATE);

    assign ins_ok = is_insert && (pos_ext <= cnt_ext) && (count_reg < CW'(CAPACITY));
    assign acc_ok = !is_insert && (pos_ext < cnt_ext);
    assign done   = ins_ok || acc_ok;

    // each cell decides on its own whether to shift, take the new value or hold
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CMPW-1:0] IDX = CMPW'(i);
        logic signed [DATA_W-1:0] below;
        logic signed [DATA_W-1:0] above;

        if (i == 0) begin : g_first
            assign below = entries_reg[i];
        end
        else begin : g_mid_lo
            assign below = entries_reg[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign above = entries_reg[i];
        end
        else begin : g_mid_hi
            assign above = entries_reg[i+1];
        end

        always_comb
        begin
            entries_next[i] = entries_reg[i];
            if (ins_ok) begin
                if (IDX == pos_ext) begin
                    entries_next[i] = req.value;
                end
                else if (IDX > pos_ext && IDX <= cnt_ext) begin
                    entries_next[i] = below;
                end
            end
            else if (acc_ok && is_erase) begin
                if (IDX >= pos_ext && (IDX + CMPW'(1)) < cnt_ext) begin
                    entries_next[i] = above;
                end
            end
            else if (acc_ok && is_update) begin
                if (IDX == pos_ext) begin
                    entries_next[i] = req.value;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (exec) begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok) begin
            count_next = count_reg + CW'(1);
        end
        else if (acc_ok && is_erase) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end
        else if (exec) begin
            count_reg <= count_next;
        end
    end

    // position is below count on a good find, so the index stays in range
    assign rd_idx = pos_ext[IW-1:0];

    always_comb
    begin
        rsp.ok         = done;
        rsp.read_value = '0;
        if (acc_ok && is_find) begin
            rsp.read_value = entries_reg[rd_idx];
        end
        rsp.length = LEN_W'(count_next);
    end

endmodule

@@ src/indexed_sequence_store_core.sv @@
// path: request register, then response register, from request beat to response valid
// one request per cycle unless stalled; every cell shifts, loads or holds in the same cycle
// a response waiting on rsp_ready stalls execution, and req_ready drops once the request
// register is also full
// reset: async active low, clears the length count and both valid flags; entries are not cleared
module indexed_sequence_store_core
    import isc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    req_t req_reg;
    logic req_valid_reg;
    logic req_valid_next;
    rsp_t rsp_reg;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_calc;
    logic exec;

    assign exec      = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || exec;

    assign req_valid_next = (req_valid && req_ready) || (req_valid_reg && !exec);
    assign rsp_valid_next = exec || (rsp_valid_reg && !rsp_ready);

    isc_cells #(
        .CAPACITY (CAPACITY)
    ) u_cells (
        .clk   (clk),
        .rst_n (rst_n),
        .exec  (exec),
        .req   (req_reg),
        .rsp   (rsp_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready) begin
            req_reg <= req;
        end
        if (exec) begin
            rsp_reg <= rsp_calc;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ sim/sequence_store_checker.sv @@
`timescale 1ns / 1ps

module sequence_store_checker
    import isc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding
);

    logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
    int                       shadow_len;
    rsp_t                     expected_rsp [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
        shadow_len  = 0;
    end

    function automatic rsp_t apply_request(input req_t r);
        rsp_t res;
        int   pos;
        int   i;
        res = '0;
        pos = int'(r.position);
        if (r.func == OP_INSERT) begin
            if (pos <= shadow_len && shadow_len < CAPACITY) begin
                for (i = shadow_len; i > pos; i--)
                    shadow_entries[i] = shadow_entries[i-1];
                shadow_entries[pos] = r.value;
                shadow_len++;
                res.ok = 1'b1;
            end
        end else if (pos < shadow_len && pos < CAPACITY) begin
            case (r.func)
                OP_ERASE:
                begin
                    for (i = pos; i + 1 < shadow_len; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_len--;
                end
                OP_FIND:
                begin
                    res.read_value = shadow_entries[pos];
                end
                default:
                begin
                    shadow_entries[pos] = r.value;
                end
            endcase
            res.ok = 1'b1;
        end
        res.length = shadow_len[LEN_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n) begin
            expected_rsp.delete();
            shadow_len  = 0;
            outstanding = 0;
        end else begin
            if (req_valid && req_ready)
                expected_rsp.push_back(apply_request(req));
            if (rsp_valid && rsp_ready) begin
                if (expected_rsp.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected response beat: ok=%0b rd=%0d len=%0d",
                                 $realtime, rsp.ok, rsp.read_value, rsp.length);
                    mismatches++;
                end else begin
                    want = expected_rsp.pop_front();
                    if (rsp.ok !== want.ok || rsp.read_value !== want.read_value
                        || rsp.length !== want.length) begin
                        if (mismatches < 10)
                            $display("%0t: exp ok=%0b rd=%0d len=%0d, got ok=%0b rd=%0d len=%0d",
                                     $realtime, want.ok, want.read_value, want.length,
                                     rsp.ok, rsp.read_value, rsp.length);
                        mismatches++;
                    end
                end
            end
            outstanding = expected_rsp.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import isc_pkg::*;

    localparam int CAPACITY  = CAPACITY_DEF;
    localparam int NUM_ITEMS = 1800;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    int   mismatches;
    int   outstanding;

    logic idling;
    logic hold_rsp;
    int   stored_len;
    logic growing;

    indexed_sequence_store_core #(.CAPACITY(CAPACITY)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    sequence_store_checker #(.CAPACITY(CAPACITY)) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    // response side: random back-pressure plus one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        rsp_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_rsp && !hold_done) begin
                hold_done = 1'b1;
                rsp_ready <= 1'b0;
                repeat (80) @(negedge clk);
            end
            rsp_ready <= !idling || ($urandom_range(99) >= 28);
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge after the beat
    task automatic send_request(input logic [1:0] f, input int p,
                                input logic signed [DATA_W-1:0] v);
        req_t item;
        item.func     = f;
        item.position = p[POS_W-1:0];
        item.value    = v;
        while (idling && $urandom_range(99) < 28) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
        // track length only to steer positions toward legal places
        if (f == OP_INSERT && item.position <= stored_len && stored_len < CAPACITY)
            stored_len++;
        else if (f != OP_INSERT && item.position < stored_len && f == OP_ERASE)
            stored_len--;
    endtask

    task automatic send_random();
        logic [1:0] f;
        int         p;
        int         r;
        r = $urandom_range(99);
        if (stored_len == CAPACITY)
            growing = 1'b0;
        else if (stored_len == 0)
            growing = 1'b1;
        else if ($urandom_range(99) < 3)
            growing = !growing;
        if (r < 10) begin
            // noise: anything the fields allow
            f = 2'($urandom_range(3));
            p = $urandom_range(31);
        end else begin
            r = $urandom_range(99);
            if (r < 20)
                f = OP_FIND;
            else if (r < 40)
                f = OP_UPDATE;
            else if (r < 70)
                f = growing ? OP_INSERT : OP_ERASE;
            else if (r < 80)
                f = growing ? OP_ERASE : OP_INSERT;
            else
                f = growing ? OP_INSERT : OP_ERASE;
            if (f == OP_INSERT)
                p = $urandom_range(stored_len);
            else if (stored_len > 0)
                p = $urandom_range(stored_len - 1);
            else
                p = $urandom_range(31);
        end
        send_request(f, p, pick_value());
    endtask

    initial begin
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        idling     = 1'b1;
        hold_rsp   = 1'b0;
        stored_len = 0;
        growing    = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // rejects on an empty store
        send_request(OP_FIND,   0,  32'sh1234_5678);
        send_request(OP_ERASE,  31, '0);
        send_request(OP_UPDATE, 0,  32'sh0f0f_0f0f);
        send_request(OP_INSERT, 1,  32'sh1111_1111);
        // front, end and middle inserts with extreme values
        send_request(OP_INSERT, 0,  32'sh7fff_ffff);
        send_request(OP_INSERT, 0,  32'sh8000_0000);
        send_request(OP_INSERT, 2,  '1);
        send_request(OP_INSERT, 1,  32'sh5555_5555);
        send_request(OP_FIND,   1,  '0);
        send_request(OP_UPDATE, 3,  32'shaaaa_aaaa);
        send_request(OP_FIND,   3,  '1);
        send_request(OP_FIND,   4,  '0);
        send_request(OP_ERASE,  0,  '0);
        send_request(OP_ERASE,  2,  '0);
        // fill up, then try past capacity
        while (stored_len < CAPACITY)
            send_request(OP_INSERT, $urandom_range(stored_len), pick_value());
        send_request(OP_INSERT, 16, 32'sh2222_2222);
        send_request(OP_INSERT, 0,  32'sh3333_3333);
        send_request(OP_FIND,   15, '0);
        send_request(OP_FIND,   16, '0);
        send_request(OP_UPDATE, 31, '1);
        send_request(OP_ERASE,  15, '0);

        for (int n = 0; n < NUM_ITEMS; n++) begin
            if (n == 400)
                hold_rsp = 1'b1;
            if (n == 900) begin
                // drain everything before carrying on
                req_valid <= 1'b0;
                wait (outstanding == 0);
                @(negedge clk);
            end
            if (n == 1100)
                idling = 1'b0;
            if (n == 1400)
                idling = 1'b1;
            send_random();
        end
        req_valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
